FILE: rtl/core/jdqt_pkg.sv
// Package for the JPEG DQT segment parser: parser phases, status codes,
// the per-word result record and the zigzag-to-natural index table.
// No dependencies.
`timescale 1ns / 1ps

package jdqt_pkg;

  // Fixed geometry of a quantization table
  localparam int TABLE_ENTRIES = 64;
  localparam int ENTRY_IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int DEST_W        = 4;
  localparam int MASK_OUT_W    = 4;
  localparam int TABLE_ID_W    = 2;
  localparam int LEN_HDR_BYTES = 2;

  // Parser phase within a segment
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN_LO,
    PH_HEADER,
    PH_DATA_HI,
    PH_DATA_LO
  } phase_e;

  // Per-word status code
  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_DEST,
    ST_TRUNC
  } status_e;

  // One result word
  typedef struct packed {
    logic                   entry_write;
    logic [TABLE_ID_W-1:0]  table_id;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [15:0]            entry_value;
    logic                   table_done;
    logic                   segment_done;
    status_e                status;
    logic [MASK_OUT_W-1:0]  valid_mask;
  } dqt_res_t;

  // Zigzag position to natural-order index
  localparam logic [ENTRY_IDX_W-1:0] ZIGZAG_ROM [TABLE_ENTRIES] = '{
     0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
    12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
    35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
    58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
  };

endpackage

FILE: rtl/core/jdqt_ctrl.sv
// Parser state machine and per-byte datapath of the DQT segment parser.
// Holds the segment/table state and forms the result word for the current byte.
// Depends on jdqt_pkg.
`timescale 1ns / 1ps

module jdqt_ctrl import jdqt_pkg::*; #(
  parameter int NUM_TABLES = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] data_byte_i,
  input  logic       seg_start_i,
  output dqt_res_t   res_o
);

  localparam int MASK_W = NUM_TABLES;

  phase_e                 phase_q, phase_d, phase_step;
  logic [15:0]            bytes_left_q, bytes_left_d;
  logic [ENTRY_IDX_W-1:0] count_q, count_d;
  logic [DEST_W-1:0]      table_q, table_d;
  logic                   wide_q, wide_d;
  logic [7:0]             hold_q, hold_d;
  logic                   skip_q, skip_d;
  logic [MASK_W-1:0]      mask_q, mask_d;

  logic [15:0]       seg_len;
  logic [15:0]       len_rem;
  logic [15:0]       bytes_dec;
  logic              consume;
  logic              seg_end;
  logic              last_entry;
  logic [DEST_W-1:0] hdr_dest;
  logic              hdr_wide;
  logic              hdr_bad;
  logic [MASK_W-1:0] dest_bit;

  // Decode the current byte
  assign seg_len    = {hold_q, data_byte_i};
  assign len_rem    = (seg_len > 16'(LEN_HDR_BYTES)) ? seg_len - 16'(LEN_HDR_BYTES) : '0;
  assign hdr_dest   = data_byte_i[DEST_W-1:0];
  assign hdr_wide   = (data_byte_i[7:4] != 4'd0);
  assign hdr_bad    = ({1'b0, hdr_dest} >= (DEST_W+1)'(NUM_TABLES));
  assign last_entry = (count_q == ENTRY_IDX_W'(TABLE_ENTRIES - 1));
  assign consume    = !seg_start_i &&
                      (phase_q == PH_HEADER || phase_q == PH_DATA_HI || phase_q == PH_DATA_LO);
  assign bytes_dec  = (bytes_left_q == 16'd0) ? 16'd0 : bytes_left_q - 16'd1;
  assign seg_end    = consume && (bytes_dec == 16'd0);

  // One-hot select of the current table in the loaded mask
  always_comb begin
    dest_bit = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (table_q == DEST_W'(i)) dest_bit[i] = 1'b1;
    end
  end

  // Next phase before the end-of-segment check
  always_comb begin
    phase_step = phase_q;
    if (seg_start_i) begin
      phase_step = PH_LEN_LO;
    end else begin
      case (phase_q)
        PH_IDLE:    phase_step = PH_IDLE;
        PH_LEN_LO:  phase_step = (len_rem == 16'd0) ? PH_IDLE : PH_HEADER;
        PH_HEADER:  phase_step = hdr_wide ? PH_DATA_HI : PH_DATA_LO;
        PH_DATA_HI: phase_step = PH_DATA_LO;
        PH_DATA_LO: begin
          if (last_entry) phase_step = PH_HEADER;
          else            phase_step = wide_q ? PH_DATA_HI : PH_DATA_LO;
        end
        default:    phase_step = PH_IDLE;
      endcase
    end
  end

  // Next phase: drop to idle when the segment runs out
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      phase_d = seg_end ? PH_IDLE : phase_step;
    end
  end

  // Datapath state update
  always_comb begin
    bytes_left_d = bytes_left_q;
    count_d      = count_q;
    table_d      = table_q;
    wide_d       = wide_q;
    hold_d       = hold_q;
    skip_d       = skip_q;
    mask_d       = mask_q;
    if (step_i) begin
      if (seg_start_i) begin
        hold_d       = data_byte_i;
        bytes_left_d = '0;
        count_d      = '0;
        skip_d       = 1'b0;
      end else begin
        case (phase_q)
          PH_LEN_LO: bytes_left_d = len_rem;
          PH_HEADER: begin
            table_d = hdr_dest;
            wide_d  = hdr_wide;
            skip_d  = hdr_bad;
            count_d = '0;
          end
          PH_DATA_HI: hold_d = data_byte_i;
          PH_DATA_LO: begin
            count_d = last_entry ? '0 : count_q + ENTRY_IDX_W'(1);
            if (last_entry && !skip_q) mask_d = mask_q | dest_bit;
          end
          default: ;
        endcase
        if (consume) bytes_left_d = bytes_dec;
      end
    end
  end

  // Result word for the current byte
  always_comb begin
    res_o              = '0;
    res_o.status       = ST_OK;
    res_o.valid_mask   = MASK_OUT_W'(mask_d);
    if (!seg_start_i) begin
      if (phase_q == PH_DATA_LO && !skip_q) begin
        res_o.entry_write = 1'b1;
        res_o.table_id    = table_q[TABLE_ID_W-1:0];
        res_o.entry_index = ZIGZAG_ROM[count_q];
        res_o.entry_value = wide_q ? {hold_q, data_byte_i} : {8'd0, data_byte_i};
        res_o.table_done  = last_entry;
      end
      if (phase_q == PH_HEADER && hdr_bad) res_o.status = ST_BAD_DEST;
      if (seg_end && phase_step != PH_HEADER) res_o.status = ST_TRUNC;
      res_o.segment_done = seg_end || (phase_q == PH_LEN_LO && len_rem == 16'd0);
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bytes_left_q <= '0;
      count_q      <= '0;
      table_q      <= '0;
      wide_q       <= 1'b0;
      hold_q       <= '0;
      skip_q       <= 1'b0;
      mask_q       <= '0;
    end else begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      count_q      <= count_d;
      table_q      <= table_d;
      wide_q       <= wide_d;
      hold_q       <= hold_d;
      skip_q       <= skip_d;
      mask_q       <= mask_d;
    end
  end

endmodule

FILE: rtl/core/jpeg_dqt_segment_parser.sv
// JPEG DQT marker segment parser, one segment byte per word in, one result word out.
// Top level: handshake and output register around jdqt_ctrl. Depends on jdqt_pkg and jdqt_ctrl.
`timescale 1ns / 1ps

// Feed the segment bytes starting at the high length byte, with seg_start_i set
// on that byte. Every accepted byte yields exactly one result word in the next
// cycle; a byte can be accepted every cycle unless in_stall_o is high, so
// throughput is one byte per clock without stalls. The single output register
// holds the word, and in_stall_o rises only while that register holds a word
// the consumer is stalling. Entries are written at natural-order indexes;
// valid_mask shows the tables loaded since reset, including the byte just reported.
module jpeg_dqt_segment_parser import jdqt_pkg::*; #(
  parameter int NUM_TABLES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        seg_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        entry_write_o,
  output logic [1:0]  table_id_o,
  output logic [5:0]  entry_index_o,
  output logic [15:0] entry_value_o,
  output logic        table_done_o,
  output logic        segment_done_o,
  output logic [1:0]  status_o,
  output logic [3:0]  valid_mask_o
);

  logic     in_accept;
  logic     out_valid_q, out_valid_d;
  dqt_res_t res_q, res_d, step_res;

  // Accept while the output register is empty or draining
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  jdqt_ctrl #(
    .NUM_TABLES(NUM_TABLES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_accept),
    .data_byte_i (data_byte_i),
    .seg_start_i (seg_start_i),
    .res_o       (step_res)
  );

  // Load a new word on accept, clear valid when the word is taken
  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
      res_d       = step_res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o    = out_valid_q;
  assign entry_write_o  = res_q.entry_write;
  assign table_id_o     = res_q.table_id;
  assign entry_index_o  = res_q.entry_index;
  assign entry_value_o  = res_q.entry_value;
  assign table_done_o   = res_q.table_done;
  assign segment_done_o = res_q.segment_done;
  assign status_o       = res_q.status;
  assign valid_mask_o   = res_q.valid_mask;

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with an empty output register");

  a_accept_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("accepted byte produced no result word");

  a_done_with_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.table_done) |-> res_q.entry_write)
    else $error("table done without an entry write");

  a_trunc_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status == ST_TRUNC) |-> res_q.segment_done)
    else $error("truncation reported before segment end");

endmodule

FILE: tb/sv/tb_jpeg_dqt_segment_parser.sv
`timescale 1ns / 1ps
// Self-checking testbench for jpeg_dqt_segment_parser: streams DQT segment bytes
// over valid/stall, predicts every result word and checks it field by field.
// Depends on jdqt_pkg and the parser RTL.

module tb_jpeg_dqt_segment_parser;
  import jdqt_pkg::*;

  localparam int NUM_DEST     = 4;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 1300;
  localparam int MAX_GAP      = 20;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i    = 8'h00;
  logic        seg_start_i    = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic        entry_write_o;
  logic [1:0]  table_id_o;
  logic [5:0]  entry_index_o;
  logic [15:0] entry_value_o;
  logic        table_done_o;
  logic        segment_done_o;
  logic [1:0]  status_o;
  logic [3:0]  valid_mask_o;

  always #4 clk_i = ~clk_i;

  jpeg_dqt_segment_parser #(
    .NUM_TABLES(NUM_DEST)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .seg_start_i   (seg_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .entry_write_o (entry_write_o),
    .table_id_o    (table_id_o),
    .entry_index_o (entry_index_o),
    .entry_value_o (entry_value_o),
    .table_done_o  (table_done_o),
    .segment_done_o(segment_done_o),
    .status_o      (status_o),
    .valid_mask_o  (valid_mask_o)
  );

  // Zigzag scan position to natural-order index
  logic [5:0] zigzag_to_natural [64] = '{
     0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
    12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
    35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
    58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
  };

  // Shadow parser state
  phase_e      sh_phase      = PH_IDLE;
  logic [15:0] sh_bytes_left = '0;
  logic [6:0]  sh_count      = '0;
  logic [3:0]  sh_dest       = '0;
  logic        sh_wide       = 1'b0;
  logic [7:0]  sh_hold       = '0;
  logic        sh_skip       = 1'b0;
  logic [3:0]  sh_loaded     = '0;

  dqt_res_t results_due [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  int segment_bytes  = 0;
  int segments_seen  = 0;
  int writes_due     = 0;
  int tables_due     = 0;
  int bad_dest_due   = 0;
  int trunc_due      = 0;
  int dest_cycle     = 0;

  // Advance the shadow parser by one byte and return the word it must produce
  function automatic dqt_res_t parse_segment_byte(input logic [7:0] b, input logic start);
    dqt_res_t    r;
    logic        consume;
    logic [15:0] seg_len;
    r       = '0;
    consume = 1'b0;
    if (start) begin
      sh_hold       = b;
      sh_bytes_left = '0;
      sh_count      = '0;
      sh_skip       = 1'b0;
      sh_phase      = PH_LEN_LO;
    end else begin
      case (sh_phase)
        PH_LEN_LO: begin
          seg_len       = {sh_hold, b};
          sh_bytes_left = (seg_len > 16'd2) ? seg_len - 16'd2 : 16'd0;
          if (sh_bytes_left == 16'd0) begin
            r.segment_done = 1'b1;
            sh_phase       = PH_IDLE;
          end else begin
            sh_phase = PH_HEADER;
          end
        end
        PH_HEADER: begin
          sh_dest  = b[3:0];
          sh_wide  = (b[7:4] != 4'h0);
          sh_skip  = (sh_dest >= NUM_DEST);
          sh_count = '0;
          if (sh_skip) r.status = ST_BAD_DEST;
          sh_phase = sh_wide ? PH_DATA_HI : PH_DATA_LO;
          consume  = 1'b1;
        end
        PH_DATA_HI: begin
          sh_hold  = b;
          sh_phase = PH_DATA_LO;
          consume  = 1'b1;
        end
        PH_DATA_LO: begin
          if (!sh_skip) begin
            r.entry_write = 1'b1;
            r.table_id    = sh_dest[1:0];
            r.entry_index = zigzag_to_natural[sh_count[5:0]];
            r.entry_value = sh_wide ? {sh_hold, b} : {8'h00, b};
          end
          sh_count = sh_count + 7'd1;
          if (sh_count >= 7'd64) begin
            if (!sh_skip) begin
              r.table_done           = 1'b1;
              sh_loaded[sh_dest[1:0]] = 1'b1;
            end
            sh_count = '0;
            sh_phase = PH_HEADER;
          end else begin
            sh_phase = sh_wide ? PH_DATA_HI : PH_DATA_LO;
          end
          consume = 1'b1;
        end
        default: sh_phase = PH_IDLE;
      endcase
    end
    // Count down the segment; ending anywhere but a table boundary truncates
    if (consume) begin
      if (sh_bytes_left > 16'd0) sh_bytes_left = sh_bytes_left - 16'd1;
      if (sh_bytes_left == 16'd0) begin
        r.segment_done = 1'b1;
        if (sh_phase != PH_HEADER) r.status = ST_TRUNC;
        sh_phase = PH_IDLE;
      end
    end
    r.valid_mask = sh_loaded;
    return r;
  endfunction

  // Offer one byte, hold it until accepted, then record its expected word
  task automatic send_byte(input logic [7:0] b, input logic start);
    int       gap;
    dqt_res_t r;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    seg_start_i <= start;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    if (start || sh_phase != PH_IDLE) segment_bytes++;
    if (start) segments_seen++;
    r = parse_segment_byte(b, start);
    if (r.entry_write) writes_due++;
    if (r.table_done) tables_due++;
    if (r.status == ST_BAD_DEST) bad_dest_due++;
    if (r.status == ST_TRUNC) trunc_due++;
    results_due.push_back(r);
  endtask

  // Drop valid and hold off until every outstanding word has come back
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_due.size() != 0);
  endtask

  // Random receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Compare each word the receiver takes with the oldest expectation
  always @(negedge clk_i) begin : check_results
    dqt_res_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        $error("result word with no byte outstanding");
        error_count++;
      end else begin
        due = results_due.pop_front();
        check_field("entry_write", due.entry_write, entry_write_o);
        check_field("table_id", due.table_id, table_id_o);
        check_field("entry_index", due.entry_index, entry_index_o);
        check_field("entry_value", due.entry_value, entry_value_o);
        check_field("table_done", due.table_done, table_done_o);
        check_field("segment_done", due.segment_done, segment_done_o);
        check_field("status", due.status, status_o);
        check_field("valid_mask", due.valid_mask, valid_mask_o);
      end
    end
  end

  // Bytes outside a segment are ignored
  task automatic test_idle_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // Lengths 0, 1 and 2 close the segment on the low length byte
  task automatic test_short_lengths();
    int len;
    for (len = 0; len < 3; len++) begin
      send_byte(8'h00, 1'b1);
      send_byte(8'(len), 1'b0);
    end
  endtask

  // Segment ends on an invalid header byte: truncation wins over bad destination
  task automatic test_header_truncation();
    send_byte(8'h00, 1'b1);
    send_byte(8'h03, 1'b0);
    send_byte(8'hF4, 1'b0);
  endtask

  // Invalid destination: entry bytes are eaten without writes
  task automatic test_bad_destination();
    send_byte(8'h00, 1'b1);
    send_byte(8'h05, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // Restart in the middle of a wide entry and again on the low length byte
  task automatic test_restart();
    send_byte(8'h00, 1'b1);
    send_byte(8'h0A, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h03, 1'b0);
    send_byte(8'h01, 1'b0);
  endtask

  // One random segment (mostly well formed, some truncated, abandoned or overlong) or one to four stray bytes
  task automatic send_random_segment();
    logic [7:0]  body [$];
    logic [15:0] seg_len;
    logic [15:0] v;
    logic [3:0]  prec;
    logic [3:0]  dest;
    int          pick, ntab, t, e, k, i, extra;
    pick = $urandom_range(99);
    // stray bytes between segments
    if (pick >= 95) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)), 1'b0);
      return;
    end
    ntab = ($urandom_range(99) < 70) ? 1 : $urandom_range(2, 3);
    for (t = 0; t < ntab; t++) begin
      if ($urandom_range(99) < 85) begin
        dest = 4'(dest_cycle % NUM_DEST);
        dest_cycle++;
      end else begin
        dest = 4'($urandom_range(NUM_DEST, 15));
      end
      prec = ($urandom_range(99) < 60) ? 4'h0 : 4'($urandom_range(1, 15));
      body.push_back({prec, dest});
      for (e = 0; e < 64; e++) begin
        v = 16'($urandom);
        case ($urandom_range(19))
          0: v = 16'h0000;
          1: v = 16'hFFFF;
          default: ;
        endcase
        if (prec != 4'h0) body.push_back(v[15:8]);
        body.push_back(v[7:0]);
      end
    end
    seg_len = 16'(body.size() + 2);
    if (pick >= 65 && pick < 78) begin
      seg_len = 16'($urandom_range(0, body.size() + 1));
    end else if (pick >= 88) begin
      seg_len = 16'($urandom_range(body.size() + 3, 16'hFFFF));
      extra = $urandom_range(0, 3);
      for (i = 0; i < extra; i++) body.push_back(8'($urandom_range(255)));
    end
    body.push_front(seg_len[7:0]);
    // bytes sent after the high length byte
    k = body.size();
    if (pick >= 65 && pick < 78) begin
      k = (seg_len > 16'd2) ? int'(seg_len) - 1 : 1;
    end else if (pick >= 78 && pick < 88) begin
      k = $urandom_range(0, body.size() - 1);
    end
    send_byte(seg_len[15:8], 1'b1);
    for (i = 0; i < k; i++) send_byte(body[i], 1'b0);
  endtask

  // Random segments under four idling mixes, draining between them
  task automatic test_random_segments();
    int base;
    int stage;
    base = segment_bytes;
    for (stage = 0; stage < 4; stage++) begin
      case (stage)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      while (segment_bytes < base + RANDOM_BYTES * (stage + 1) / 4) send_random_segment();
      wait_results_drained();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_bytes();
    test_short_lengths();
    test_header_truncation();
    test_bad_destination();
    test_restart();
    wait_results_drained();
    test_random_segments();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk_i);
    $display("Parsed %0d segment bytes in %0d segments: %0d entry writes, %0d tables loaded.",
             segment_bytes, segments_seen, writes_due, tables_due);
    $display("Flagged %0d invalid destinations and %0d truncations; final table mask %b.",
             bad_dest_due, trunc_due, sh_loaded);
    if (error_count == 0 && results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/jdqt_pkg.sv
rtl/core/jdqt_ctrl.sv
rtl/core/jpeg_dqt_segment_parser.sv
tb/sv/tb_jpeg_dqt_segment_parser.sv
